[src/tcs_pkg.sv]
// Shared constants for the thermal cycle sequencer.
package tcs_pkg;

  localparam int ADC_W   = 10;
  localparam int TEMP_W  = 7;
  localparam int ANGLE_W = 8;
  localparam int CYC_W   = 8;
  localparam int CMD_W   = 8;
  localparam int PHASE_W = 3;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_START    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RUNNING  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT2    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_STOP     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_COMPLETE = 3'd5;

  localparam logic [STAT_W-1:0] ST_IDLE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RUNNING = 2'd1;
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd2;

  localparam logic [CMD_W-1:0] CMD_START = 8'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 8'd2;

  localparam logic [TEMP_W-1:0] FLOOR_TEMP = 7'd53;
  localparam logic [TEMP_W-1:0] TEMP_MAX   = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND = 3'd5;

  localparam logic [TEMP_W-1:0]  RST_UPPER  = 7'd90;
  localparam logic [TEMP_W-1:0]  RST_LOWER  = 7'd55;
  localparam logic [CYC_W-1:0]   RST_LAST   = 8'd30;
  localparam logic [ANGLE_W-1:0] RST_HOME   = 8'd0;
  localparam logic [ANGLE_W-1:0] RST_FIRST  = 8'd45;
  localparam logic [ANGLE_W-1:0] RST_SECOND = 8'd135;

  localparam int SCALE_MUL = 100;
  localparam int SCALE_DIV = 1023;
  localparam int PROD_W    = 17;
  localparam int DIV_SHIFT = 10;

endpackage

[src/tcs_scale.sv]
// Scales a raw converter sample to adc*100/1023, truncated.
module tcs_scale import tcs_pkg::*; (
  input  logic [ADC_W-1:0]  adc,
  output logic [TEMP_W-1:0] temp
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] q_est;
  logic [PROD_W-1:0] rem;

  // p>>10 underestimates p/1023 by at most one, so one correction step
  always_comb begin
    prod  = PROD_W'(adc) * PROD_W'(SCALE_MUL);
    q_est = prod >> DIV_SHIFT;
    rem   = prod - q_est * PROD_W'(SCALE_DIV);
    if (rem >= PROD_W'(SCALE_DIV)) begin
      temp = TEMP_W'(q_est + PROD_W'(1));
    end else begin
      temp = TEMP_W'(q_est);
    end
  end

endmodule

[src/thermal_cycle_sequencer.sv]
// Top level: thermal cycle phase sequencer with input and result registers.
// Each accepted beat passes from the input register to the result register.
// Throughput: one beat per cycle unless stalled; the input and result registers
// form a two-entry pipeline, so a stalled result still leaves room for one beat.
// Reset (rst_n low, synchronous): phase idle, counters and lamp cleared,
// actuator at home, registers back to their reset values, both stages empty.
module thermal_cycle_sequencer import tcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command_present,
  input  logic [CMD_W-1:0]      in_command_byte,
  input  logic [ADC_W-1:0]      in_adc_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_status_valid,
  output logic [STAT_W-1:0]     out_status_code,
  output logic [ANGLE_W-1:0]    out_actuator_angle,
  output logic                  out_lamp_on,
  output logic [PHASE_W-1:0]    out_phase_now,
  output logic [TEMP_W-1:0]     out_scaled_temp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TEMP_W-1:0]  upper_r, lower_r;
  logic [CYC_W-1:0]   last_r;
  logic [ANGLE_W-1:0] home_r, first_r, second_r;

  logic               s1_vld_r;
  logic               s1_present_r;
  logic [CMD_W-1:0]   s1_cmd_r;
  logic [ADC_W-1:0]   s1_adc_r;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CYC_W-1:0]   cyc_r, cyc_nxt;
  logic [CMD_W-1:0]   lcmd_r, lcmd_nxt;
  logic               lamp_r, lamp_nxt;
  logic [ANGLE_W-1:0] angle_r, angle_nxt;

  logic               out_valid_r;
  logic               sv_r, sv_nxt;
  logic [STAT_W-1:0]  sc_r, sc_nxt;
  logic [TEMP_W-1:0]  temp_r;

  logic [TEMP_W-1:0]  temp;
  logic [TEMP_W-1:0]  wait_limit;
  logic               end_cyc;
  logic               adv;
  logic               step;
  logic               in_acc;

  assign adv      = !out_valid_r || !out_stall;
  assign step     = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  tcs_scale u_scale (
    .adc  (s1_adc_r),
    .temp (temp)
  );

  assign wait_limit = (lower_r > FLOOR_TEMP) ? lower_r : FLOOR_TEMP;

  always_comb begin
    phase_nxt = phase_r;
    cyc_nxt   = cyc_r;
    lcmd_nxt  = lcmd_r;
    lamp_nxt  = lamp_r;
    angle_nxt = angle_r;
    sv_nxt    = 1'b0;
    sc_nxt    = ST_IDLE;
    end_cyc   = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (s1_present_r) begin
          lcmd_nxt  = s1_cmd_r;
          phase_nxt = PH_START;
        end else begin
          sv_nxt = 1'b1;
          sc_nxt = ST_IDLE;
        end
      end
      PH_START: begin
        if (lcmd_r == CMD_START) begin
          lamp_nxt  = 1'b1;
          phase_nxt = PH_RUNNING;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_RUNNING: begin
        if (s1_present_r) begin
          if (s1_cmd_r == CMD_STOP) begin
            phase_nxt = PH_STOP;
          end
        end else begin
          sv_nxt = 1'b1;
          sc_nxt = ST_RUNNING;
          if (cyc_r <= last_r) begin
            angle_nxt = first_r;
            if (temp > upper_r) begin
              angle_nxt = second_r;
              if (temp <= FLOOR_TEMP) begin
                end_cyc = 1'b1;
              end else begin
                phase_nxt = PH_WAIT2;
              end
            end
          end
        end
      end
      PH_WAIT2: begin
        angle_nxt = second_r;
        if (s1_present_r && (s1_cmd_r == CMD_STOP)) begin
          phase_nxt = PH_STOP;
        end else if (temp <= wait_limit) begin
          end_cyc = 1'b1;
        end
      end
      PH_STOP: begin
        cyc_nxt   = '0;
        lamp_nxt  = 1'b0;
        angle_nxt = home_r;
        phase_nxt = PH_IDLE;
      end
      PH_COMPLETE: begin
        sv_nxt    = 1'b1;
        sc_nxt    = ST_DONE;
        cyc_nxt   = '0;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (end_cyc) begin
      if (cyc_r == last_r) begin
        phase_nxt = PH_COMPLETE;
      end else begin
        cyc_nxt   = cyc_r + CYC_W'(1);
        phase_nxt = PH_RUNNING;
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= RST_UPPER;
      lower_r  <= RST_LOWER;
      last_r   <= RST_LAST;
      home_r   <= RST_HOME;
      first_r  <= RST_FIRST;
      second_r <= RST_SECOND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPPER:  upper_r  <= cfg_wdata[TEMP_W-1:0];
        REG_LOWER:  lower_r  <= cfg_wdata[TEMP_W-1:0];
        REG_LAST:   last_r   <= cfg_wdata;
        REG_HOME:   home_r   <= cfg_wdata;
        REG_FIRST:  first_r  <= cfg_wdata;
        REG_SECOND: second_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (step) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_present_r <= in_command_present;
      s1_cmd_r     <= in_command_byte;
      s1_adc_r     <= in_adc_sample;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cyc_r   <= '0;
      lcmd_r  <= '0;
      lamp_r  <= 1'b0;
      angle_r <= RST_HOME;
    end else if (step) begin
      phase_r <= phase_nxt;
      cyc_r   <= cyc_nxt;
      lcmd_r  <= lcmd_nxt;
      lamp_r  <= lamp_nxt;
      angle_r <= angle_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sv_r   <= sv_nxt;
      sc_r   <= sc_nxt;
      temp_r <= temp;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status_valid   = sv_r;
  assign out_status_code    = sc_r;
  assign out_actuator_angle = angle_r;
  assign out_lamp_on        = lamp_r;
  assign out_phase_now      = phase_r;
  assign out_scaled_temp    = temp_r;

endmodule

[src/tcs_checker.sv]
// Port-level assertions for the thermal cycle sequencer, bound to the top level.
module tcs_checker import tcs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_status_valid,
  input logic [STAT_W-1:0]  out_status_code,
  input logic               out_lamp_on,
  input logic [PHASE_W-1:0] out_phase_now,
  input logic [TEMP_W-1:0]  out_scaled_temp
);

  // result stage empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_phase_now)
      && $stable(out_status_code) && $stable(out_scaled_temp))
    else $error("stalled result beat changed");

  a_complete_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase_now == PH_COMPLETE) |-> !out_status_valid
      || (out_status_code == ST_RUNNING))
    else $error("complete phase entered without a running status");

  a_lamp_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_phase_now == PH_RUNNING) || (out_phase_now == PH_WAIT2))
      |-> out_lamp_on)
    else $error("lamp off during a run");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_scaled_temp <= TEMP_MAX)
      && (out_status_valid || (out_status_code == ST_IDLE)))
    else $error("scaled temperature or status code out of range");

endmodule

bind thermal_cycle_sequencer tcs_checker u_tcs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status_valid (out_status_valid),
  .out_status_code  (out_status_code),
  .out_lamp_on      (out_lamp_on),
  .out_phase_now    (out_phase_now),
  .out_scaled_temp  (out_scaled_temp)
);
